FILE: rtl/core/oil_pkg.sv
// Package for the ordered integer list engine.
// Holds the default depth, field widths, operation codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oil_pkg;

    localparam int OIL_DEPTH = 64;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 6;
    localparam int ECNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_REMOVE     = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/oil_mem.sv
// Entry store of the ordered integer list engine.
// One write port and one read port with registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module oil_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/oil_ctrl.sv
// Sequencer of the ordered integer list engine.
// Keeps the circular head and count, walks the store for search and removal,
// and registers each result. Depends on oil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oil_ctrl #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oil_pkg::OP_W-1:0]      operation,
    input  logic [oil_pkg::VALUE_W-1:0]   value,
    output logic                          we,
    output logic [ADDR_W-1:0]             waddr,
    output logic [oil_pkg::VALUE_W-1:0]   wdata,
    output logic [ADDR_W-1:0]             raddr,
    input  logic [oil_pkg::VALUE_W-1:0]   rdata,
    output logic                          done,
    output logic [oil_pkg::STAT_W-1:0]    status,
    output logic [ADDR_W-1:0]             pos,
    output logic [oil_pkg::VALUE_W-1:0]   found_value,
    output logic [CNT_W-1:0]              count
);

    import oil_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     chk_reg, chk_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic                 done_reg, done_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]   fval_reg, fval_next;

    logic [ADDR_W-1:0]    head_inc, head_dec;
    logic                 is_full, is_empty, match, at_last;

    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] hd,
                                                input logic [CNT_W:0] lpos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(hd) + lpos;
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign match    = (rdata == val_reg);
    assign at_last  = ((chk_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        chk_next    = chk_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fval_next   = fval_reg;
        we          = 1'b0;
        waddr       = phys(head_reg, {1'b0, chk_reg});
        wdata       = rdata;
        raddr       = phys(head_reg, {1'b0, chk_reg} + 1'b1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    val_next    = value;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    pos_next    = '0;
                    fval_next   = '0;
                    case (operation)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = head_dec;
                                wdata      = value;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = phys(head_reg, {1'b0, count_reg});
                                wdata      = value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH, OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                raddr      = head_reg;
                                chk_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    pos_next    = ADDR_W'(chk_reg);
                    fval_next   = val_reg;
                    status_next = STAT_OK;
                    if (op_reg == OP_REMOVE && chk_reg == '0)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_REMOVE && at_last)
                    begin
                        count_next = count_reg - 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (at_last)
                begin
                    status_next = STAT_NOTFOUND;
                    pos_next    = '0;
                    fval_next   = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                we    = 1'b1;
                raddr = phys(head_reg, {1'b0, chk_reg} + 2'd2);
                if (({1'b0, chk_reg} + 2'd2) == {1'b0, count_reg})
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg    <= chk_next;
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign pos         = pos_reg;
    assign found_value = fval_reg;
    assign count       = count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_int_list_engine_core.sv
// Top level of the ordered integer list engine.
// Joins the sequencer oil_ctrl and the entry store oil_mem; uses oil_pkg.
`timescale 1ns / 1ps
`default_nettype none

// An operation is taken when start is high and busy is low, and its result
// appears on the result ports for one cycle with done high. Pushes, pops and
// unused codes give their result in the cycle after the transfer, with busy
// staying low, so they may follow one another every cycle. Search and remove
// walk the entries through the single read port of the store at one entry a
// cycle, keeping busy high until a match or the last entry is reached, and
// a removal from the middle also shifts the later entries down one per cycle.
// The receiver cannot stall, so a result must be taken in its done cycle.
module ordered_int_list_engine_core #(
    parameter int DEPTH = oil_pkg::OIL_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [oil_pkg::OP_W-1:0]             operation,
    input  logic signed [oil_pkg::VALUE_W-1:0]   value,
    output logic                                 done,
    output logic [oil_pkg::STAT_W-1:0]           status,
    output logic [oil_pkg::FIDX_W-1:0]           found_index,
    output logic signed [oil_pkg::VALUE_W-1:0]   found_value,
    output logic [oil_pkg::ECNT_W-1:0]           entry_count
);

    import oil_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [VALUE_W-1:0]  wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [VALUE_W-1:0]  rdata;
    logic [ADDR_W-1:0]   pos;
    logic [VALUE_W-1:0]  fval;
    logic [CNT_W-1:0]    count;

    oil_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    oil_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .value       (value),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr       (raddr),
        .rdata       (rdata),
        .done        (done),
        .status      (status),
        .pos         (pos),
        .found_value (fval),
        .count       (count)
    );

    assign found_index = FIDX_W'(pos);
    assign found_value = fval;
    assign entry_count = ECNT_W'(count);

endmodule

`default_nettype wire

FILE: rtl/core/oil_checker.sv
// Port-level checks for the ordered integer list engine.
// Bound to ordered_int_list_engine_core; uses oil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oil_checker #(
    parameter int DEPTH = oil_pkg::OIL_DEPTH
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic [oil_pkg::OP_W-1:0]             operation,
    input wire logic                                 done,
    input wire logic [oil_pkg::STAT_W-1:0]           status,
    input wire logic [oil_pkg::FIDX_W-1:0]           found_index,
    input wire logic signed [oil_pkg::VALUE_W-1:0]   found_value,
    input wire logic [oil_pkg::ECNT_W-1:0]           entry_count
);

    import oil_pkg::*;

    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_PUSH_FRONT || operation == OP_PUSH_BACK ||
                            operation == OP_POP_FRONT || operation == OP_POP_BACK))
        |=> (done && !busy))
        else $error("push or pop did not finish in one cycle");

    a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (found_index == '0 && found_value == '0))
        else $error("failed operation reported a match");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> (entry_count == ECNT_W'(DEPTH)))
        else $error("full status with count below depth");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_SEARCH || operation == OP_REMOVE) &&
         entry_count != '0 && !done) |=> !done)
        else $error("search produced a result too early");

endmodule

bind ordered_int_list_engine_core oil_checker #(.DEPTH(DEPTH)) u_oil_checker (.*);

`default_nettype wire

FILE: verif/ordered_int_list_engine_core_tb.sv
// Self-checking testbench for ordered_int_list_engine_core: drives list operations with
// random gaps and checks every result against a scoreboard that keeps its own list.
// Depends on oil_pkg and the RTL of ordered_int_list_engine_core.
`timescale 1ns / 1ps

module ordered_int_list_engine_core_tb;
    import oil_pkg::*;

    localparam int DEPTH = OIL_DEPTH;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int {
        FILL_MODE,
        MIXED_MODE,
        DRAIN_MODE
    } traffic_mode_t;

    typedef struct {
        status_t                   status;
        logic [FIDX_W-1:0]         found_index;
        logic signed [VALUE_W-1:0] found_value;
        logic [ECNT_W-1:0]         entry_count;
    } list_result_t;

    class list_scoreboard;
        logic signed [VALUE_W-1:0] entries [DEPTH];
        int unsigned               held;
        list_result_t              awaited [$];
        int                        errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function void drop_at(int unsigned pos);
            for (int unsigned i = pos; i + 1 < held; i++)
            begin
                entries[i] = entries[i + 1];
            end
            held--;
        endfunction

        function void note_transfer(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
            list_result_t r;
            int unsigned  pos;
            r.status = STAT_OK;
            r.found_index = '0;
            r.found_value = '0;
            case (op)
                OP_PUSH_FRONT:
                begin
                    if (held >= DEPTH)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        for (int unsigned i = held; i > 0; i--)
                        begin
                            entries[i] = entries[i - 1];
                        end
                        entries[0] = val;
                        held++;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (held >= DEPTH)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        entries[held] = val;
                        held++;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                        drop_at(0);
                end
                OP_POP_BACK:
                begin
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                        held--;
                end
                OP_SEARCH, OP_REMOVE:
                begin
                    if (held == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < held && entries[pos] !== val)
                        begin
                            pos++;
                        end
                        if (pos == held)
                        begin
                            r.status = STAT_NOTFOUND;
                        end
                        else
                        begin
                            r.found_index = FIDX_W'(pos);
                            r.found_value = val;
                            if (op == OP_REMOVE)
                                drop_at(pos);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count = ECNT_W'(held);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [FIDX_W-1:0] idx,
                                   logic signed [VALUE_W-1:0] fv, logic [ECNT_W-1:0] cnt);
            list_result_t r;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d index %0d value %0d count %0d",
                         $time, st, idx, fv, cnt);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (st !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
            if (idx !== r.found_index)
            begin
                $display("%0t: found_index expected %0d actual %0d", $time, r.found_index, idx);
                errors++;
            end
            if (fv !== r.found_value)
            begin
                $display("%0t: found_value expected %0d actual %0d", $time, r.found_value, fv);
                errors++;
            end
            if (cnt !== r.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, r.entry_count, cnt);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic [STAT_W-1:0]         status;
    logic [FIDX_W-1:0]         found_index;
    logic signed [VALUE_W-1:0] found_value;
    logic [ECNT_W-1:0]         entry_count;

    list_scoreboard sb = new();

    ordered_int_list_engine_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .value(value),
        .done(done),
        .status(status),
        .found_index(found_index),
        .found_value(found_value),
        .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("ordered_int_list_engine_core_tb: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, found_index, found_value, entry_count);
            if (start && !busy)
                sb.note_transfer(operation, value);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
        start <= 1'b1;
        operation <= op;
        value <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sd0;
            1: return -32'sd1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return ($urandom_range(0, 1) != 0) ? 32'h5555_5555 : 32'hAAAA_AAAA;
            5: return $urandom_range(1, 6);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(traffic_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_MODE:
            begin
                if (r < 30) return OP_PUSH_FRONT;
                if (r < 60) return OP_PUSH_BACK;
                if (r < 68) return OP_POP_FRONT;
                if (r < 76) return OP_POP_BACK;
                if (r < 88) return OP_SEARCH;
                if (r < 97) return OP_REMOVE;
            end
            DRAIN_MODE:
            begin
                if (r < 10) return OP_PUSH_FRONT;
                if (r < 20) return OP_PUSH_BACK;
                if (r < 40) return OP_POP_FRONT;
                if (r < 60) return OP_POP_BACK;
                if (r < 75) return OP_SEARCH;
                if (r < 97) return OP_REMOVE;
            end
            default:
            begin
                if (r < 17) return OP_PUSH_FRONT;
                if (r < 34) return OP_PUSH_BACK;
                if (r < 50) return OP_POP_FRONT;
                if (r < 66) return OP_POP_BACK;
                if (r < 82) return OP_SEARCH;
                if (r < 97) return OP_REMOVE;
            end
        endcase
        return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    initial
    begin
        traffic_mode_t mode;
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operations on an empty list, then a short list with duplicates.
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_SPARE_LO, 32'h7FFF_FFFF);
        send_item(OP_SPARE_HI, 32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(OP_PUSH_FRONT, -32'sd1);
        send_item(OP_PUSH_BACK, 32'sd0);
        send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(OP_SEARCH, 32'h7FFF_FFFF);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_REMOVE, 32'sd12345);
        send_item(OP_REMOVE, 32'h7FFF_FFFF);
        send_item(OP_REMOVE, -32'sd1);
        send_item(OP_REMOVE, 32'h7FFF_FFFF);
        send_item(OP_SPARE_HI, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        wait_all_results();

        mode = FILL_MODE;
        for (int n = 0; n < 1500; n++)
        begin
            case ((n / 120) % 3)
                0: mode = FILL_MODE;
                1: mode = MIXED_MODE;
                default: mode = DRAIN_MODE;
            endcase
            if (n == 700)
                wait_all_results();
            else if ((n < 300 || n >= 650) && $urandom_range(0, 99) < 12)
                idle_for($urandom_range(1, 3));
            send_item(pick_operation(mode), pick_value());
        end

        wait_all_results();
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ordered_int_list_engine_core_tb: PASS");
        else
            $display("ordered_int_list_engine_core_tb: FAIL");
        $finish;
    end

endmodule
